### rtl/blzd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blzd_pkg
// Shared types and constants for the backward LZ bitstream decompressor.
// ----------------------------------------------------------------------------
package blzd_pkg;

    localparam int DIST_BITS = 13;
    localparam int LEVELS    = 4;
    localparam logic [7:0] EXT_CONT = 8'hFF;

    // Token decode phase
    typedef enum logic [2:0] {
        PH_FLAG  = 3'd0,
        PH_LIT   = 3'd1,
        PH_DIST  = 3'd2,
        PH_LEVEL = 3'd3,
        PH_EXT   = 3'd4,
        PH_COPY  = 3'd5
    } phase_t;

    // Back-end sequencer state
    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_START = 3'd1,
        ST_BITS  = 3'd2,
        ST_CP_RD = 3'd3,
        ST_CP_WR = 3'd4,
        ST_FIN   = 3'd5,
        ST_LAST  = 3'd6
    } state_t;

    // One queued input item
    typedef struct packed {
        logic       req_type;
        logic [7:0] comp_byte;
    } item_t;

    // One result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       burst_last;
        logic       copy_pending;
        logic       done_res;
        logic       bad_reference;
    } res_t;

    // Bit width of each length level
    function automatic logic [3:0] level_width(input logic [1:0] lvl);
        logic [3:0] w;
        case (lvl)
            2'd0:    w = 4'd2;
            2'd1:    w = 4'd3;
            2'd2:    w = 4'd5;
            default: w = 4'd8;
        endcase
        return w;
    endfunction

endpackage

### rtl/blzd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blzd_front
// Input front end: two-entry queue that decouples the input channel from
// the decode engine.
// ----------------------------------------------------------------------------
module blzd_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [7:0]           s_comp_byte,
    output logic                 q_valid,
    output blzd_pkg::item_t      q_item,
    input  logic                 q_pop
);

    blzd_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            push;
    logic            pop;

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the transfer payload
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= '{req_type: s_req_type, comp_byte: s_comp_byte};
        end
    end

endmodule

### rtl/blzd_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blzd_engine
// Decode engine: bit-serial token decoder, history memory, copy sequencer
// and result output stage.
// ----------------------------------------------------------------------------
module blzd_engine #(
    parameter int HISTORY_DEPTH = 16384,
    parameter int MAX_BURST     = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [31:0]          size,
    input  logic                 q_valid,
    input  blzd_pkg::item_t      q_item,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output blzd_pkg::res_t       m_res
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int NW = $clog2(MAX_BURST + 1);
    localparam logic [AW:0]   DEPTH_C = (AW + 1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);
    localparam logic [NW-1:0] MAXB_C = NW'(MAX_BURST);

    logic [7:0] hist_mem [HISTORY_DEPTH];

    blzd_pkg::state_t state_reg, state_next;
    blzd_pkg::phase_t phase_reg, phase_next;
    blzd_pkg::item_t  item_reg, item_next;
    logic [7:0]    pool_reg, pool_next;
    logic [3:0]    bits_reg, bits_next;
    logic [12:0]   acc_reg, acc_next;
    logic [3:0]    got_reg, got_next;
    logic [2:0]    level_reg, level_next;
    logic [31:0]   rem_reg, rem_next;
    logic [13:0]   dist_reg, dist_next;
    logic [31:0]   prod_reg, prod_next;
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [NW-1:0] n_reg, n_next;
    logic [7:0]    rdata_reg;
    logic          hold_v_reg, hold_v_next;
    blzd_pkg::res_t hold_reg, hold_next;
    logic          out_v_reg, out_v_next;
    blzd_pkg::res_t out_reg, out_next;

    logic          done;
    logic          can_emit;
    logic          emit;
    blzd_pkg::res_t emit_res;
    logic          mem_we;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] rd_addr;
    logic          bit_in;
    logic [12:0]   acc_sh;
    logic [3:0]    got_inc;
    logic [3:0]    lw;
    logic [12:0]   lmask;
    logic [32:0]   rem_sum;
    logic [31:0]   rem_sat;
    logic          cp_bad;
    logic [7:0]    cp_byte;
    logic [AW:0]   addr_wide;

    assign done     = (prod_reg >= size);
    assign can_emit = !hold_v_reg || !out_v_reg || m_ready;
    assign m_valid  = out_v_reg;
    assign m_res    = out_reg;

    // Source address for the copy read, wrapped into the history
    always_comb begin
        if ({1'b0, wptr_reg} >= (AW + 1)'(dist_reg)) begin
            addr_wide = {1'b0, wptr_reg} - (AW + 1)'(dist_reg);
        end else begin
            addr_wide = {1'b0, wptr_reg} + DEPTH_C - (AW + 1)'(dist_reg);
        end
        rd_addr = addr_wide[AW-1:0];
    end

    // Next state, decode and result generation
    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        item_next   = item_reg;
        pool_next   = pool_reg;
        bits_next   = bits_reg;
        acc_next    = acc_reg;
        got_next    = got_reg;
        level_next  = level_reg;
        rem_next    = rem_reg;
        dist_next   = dist_reg;
        prod_next   = prod_reg;
        wptr_next   = wptr_reg;
        n_next      = n_reg;
        q_pop       = 1'b0;
        emit        = 1'b0;
        emit_res    = '0;
        mem_we      = 1'b0;
        mem_wdata   = 8'd0;
        mem_re      = 1'b0;
        bit_in      = pool_reg[3'(bits_reg - 4'd1)];
        acc_sh      = {acc_reg[11:0], bit_in};
        got_inc     = got_reg + 4'd1;
        lw          = blzd_pkg::level_width(level_reg[1:0]);
        lmask       = (13'd1 << lw) - 13'd1;
        rem_sum     = {1'b0, rem_reg} + 33'(acc_sh);
        rem_sat     = rem_sum[32] ? 32'hFFFF_FFFF : rem_sum[31:0];
        cp_bad      = (32'(dist_reg) > prod_reg);
        cp_byte     = cp_bad ? 8'd0 : rdata_reg;

        case (state_reg)
            blzd_pkg::ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    n_next     = '0;
                    state_next = blzd_pkg::ST_START;
                end
            end
            blzd_pkg::ST_START: begin
                if (done) begin
                    state_next = blzd_pkg::ST_FIN;
                end else if (!item_reg.req_type) begin
                    if (phase_reg != blzd_pkg::PH_COPY) begin
                        pool_next  = item_reg.comp_byte;
                        bits_next  = 4'd8;
                        state_next = blzd_pkg::ST_BITS;
                    end else begin
                        state_next = blzd_pkg::ST_FIN;
                    end
                end else if (phase_reg == blzd_pkg::PH_COPY) begin
                    state_next = blzd_pkg::ST_CP_RD;
                end else begin
                    state_next = blzd_pkg::ST_BITS;
                end
            end
            blzd_pkg::ST_BITS: begin
                if (bits_reg == 4'd0 || phase_reg == blzd_pkg::PH_COPY || done) begin
                    state_next = blzd_pkg::ST_FIN;
                end else if (can_emit) begin
                    // Consume one bit, MSB first
                    bits_next = bits_reg - 4'd1;
                    acc_next  = acc_sh;
                    got_next  = got_inc;
                    case (phase_reg)
                        blzd_pkg::PH_FLAG: begin
                            phase_next = bit_in ? blzd_pkg::PH_DIST : blzd_pkg::PH_LIT;
                            acc_next   = 13'd0;
                            got_next   = 4'd0;
                        end
                        blzd_pkg::PH_LIT: begin
                            if (got_inc == 4'd8) begin
                                mem_we    = 1'b1;
                                mem_wdata = acc_sh[7:0];
                                prod_next = prod_reg + 32'd1;
                                wptr_next = (wptr_reg == LAST_IDX) ? '0 : wptr_reg + AW'(1);
                                emit      = 1'b1;
                                emit_res  = '{out_byte: acc_sh[7:0], byte_valid: 1'b1,
                                              burst_last: 1'b0, copy_pending: 1'b0,
                                              done_res: (prod_next >= size),
                                              bad_reference: 1'b0};
                                phase_next = blzd_pkg::PH_FLAG;
                                acc_next   = 13'd0;
                                got_next   = 4'd0;
                            end
                        end
                        blzd_pkg::PH_DIST: begin
                            if (got_inc == 4'(blzd_pkg::DIST_BITS)) begin
                                dist_next  = 14'(acc_sh) + 14'd3;
                                rem_next   = 32'd3;
                                level_next = 3'd0;
                                phase_next = blzd_pkg::PH_LEVEL;
                                acc_next   = 13'd0;
                                got_next   = 4'd0;
                            end
                        end
                        blzd_pkg::PH_LEVEL: begin
                            if (got_inc == lw) begin
                                rem_next = rem_sat;
                                acc_next = 13'd0;
                                got_next = 4'd0;
                                if (acc_sh == lmask) begin
                                    level_next = level_reg + 3'd1;
                                    phase_next = (level_reg == 3'(blzd_pkg::LEVELS - 1)) ?
                                                 blzd_pkg::PH_EXT : blzd_pkg::PH_LEVEL;
                                end else begin
                                    phase_next = blzd_pkg::PH_COPY;
                                    state_next = blzd_pkg::ST_CP_RD;
                                end
                            end
                        end
                        blzd_pkg::PH_EXT: begin
                            if (got_inc == 4'd8) begin
                                rem_next = rem_sat;
                                acc_next = 13'd0;
                                got_next = 4'd0;
                                if (acc_sh[7:0] != blzd_pkg::EXT_CONT) begin
                                    phase_next = blzd_pkg::PH_COPY;
                                    state_next = blzd_pkg::ST_CP_RD;
                                end
                            end
                        end
                        default: begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
            blzd_pkg::ST_CP_RD: begin
                // Issue the history read or close the copy
                if (rem_reg != 32'd0 && n_reg < MAXB_C && !done) begin
                    mem_re     = 1'b1;
                    state_next = blzd_pkg::ST_CP_WR;
                end else begin
                    if (rem_reg == 32'd0 || done) begin
                        rem_next   = 32'd0;
                        phase_next = blzd_pkg::PH_FLAG;
                    end
                    state_next = blzd_pkg::ST_BITS;
                end
            end
            blzd_pkg::ST_CP_WR: begin
                if (can_emit) begin
                    mem_we    = 1'b1;
                    mem_wdata = cp_byte;
                    prod_next = prod_reg + 32'd1;
                    rem_next  = rem_reg - 32'd1;
                    wptr_next = (wptr_reg == LAST_IDX) ? '0 : wptr_reg + AW'(1);
                    emit      = 1'b1;
                    emit_res  = '{out_byte: cp_byte, byte_valid: 1'b1, burst_last: 1'b0,
                                  copy_pending: (rem_next != 32'd0) && !(prod_next >= size),
                                  done_res: (prod_next >= size), bad_reference: cp_bad};
                    state_next = blzd_pkg::ST_CP_RD;
                end
            end
            blzd_pkg::ST_FIN: begin
                // Give a status-only result when nothing was produced
                if (n_reg == '0) begin
                    emit     = 1'b1;
                    emit_res = '{out_byte: 8'd0, byte_valid: 1'b0, burst_last: 1'b0,
                                 copy_pending: (phase_reg == blzd_pkg::PH_COPY) &&
                                               (rem_reg != 32'd0) && !done,
                                 done_res: done, bad_reference: 1'b0};
                end
                state_next = blzd_pkg::ST_LAST;
            end
            blzd_pkg::ST_LAST: begin
                if (!out_v_reg || m_ready) begin
                    state_next = blzd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = blzd_pkg::ST_IDLE;
            end
        endcase

        // Result staging: hold the newest result until the next or the end
        hold_v_next = hold_v_reg;
        hold_next   = hold_reg;
        out_v_next  = out_v_reg && !m_ready;
        out_next    = out_reg;
        if (emit && n_reg < MAXB_C) begin
            n_next = n_reg + NW'(1);
            if (hold_v_reg) begin
                out_v_next = 1'b1;
                out_next   = hold_reg;
            end
            hold_v_next = 1'b1;
            hold_next   = emit_res;
        end
        if (state_reg == blzd_pkg::ST_LAST && (!out_v_reg || m_ready)) begin
            out_v_next           = 1'b1;
            out_next             = hold_reg;
            out_next.burst_last  = 1'b1;
            hold_v_next          = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= blzd_pkg::ST_IDLE;
            phase_reg  <= blzd_pkg::PH_FLAG;
            pool_reg   <= 8'd0;
            bits_reg   <= 4'd0;
            acc_reg    <= 13'd0;
            got_reg    <= 4'd0;
            level_reg  <= 3'd0;
            rem_reg    <= 32'd0;
            dist_reg   <= 14'd0;
            prod_reg   <= 32'd0;
            wptr_reg   <= '0;
            n_reg      <= '0;
            hold_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            pool_reg   <= pool_next;
            bits_reg   <= bits_next;
            acc_reg    <= acc_next;
            got_reg    <= got_next;
            level_reg  <= level_next;
            rem_reg    <= rem_next;
            dist_reg   <= dist_next;
            prod_reg   <= prod_next;
            wptr_reg   <= wptr_next;
            n_reg      <= n_next;
            hold_v_reg <= hold_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    // History memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[wptr_reg] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= hist_mem[rd_addr];
        end
    end

endmodule

### rtl/backward_lz_bitstream_decompressor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backward_lz_bitstream_decompressor_unit
// Backward-read LZ bitstream decompressor: input queue, decode engine with
// history memory, and the size configuration register.
// ----------------------------------------------------------------------------
// Sequence: after the start state an item takes one bit step per decoded
// bit and a read and a write step per copied byte (history read, then
// write), a step to close each copy, then the finish and last states;
// items run one at a time. A full output stage can hold bit and write steps.
// Reset (aresetn low, synchronous) clears all decode state and the size
// register; the history memory is not cleared and needs no clearing pass.
module backward_lz_bitstream_decompressor_unit #(
    parameter int HISTORY_DEPTH = 16384,
    parameter int MAX_BURST     = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [7:0]  s_comp_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic        m_burst_last,
    output logic        m_copy_pending,
    output logic        m_done_res,
    output logic        m_bad_reference
);

    logic [31:0]     size_reg;
    logic            q_valid;
    logic            q_pop;
    blzd_pkg::item_t q_item;
    blzd_pkg::res_t  res;

    // Hold the uncompressed size
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= 32'd0;
        end else if (cfg_wr_en) begin
            size_reg <= cfg_wr_data;
        end
    end

    blzd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_comp_byte (s_comp_byte),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    blzd_engine #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MAX_BURST     (MAX_BURST)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .size    (size_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (res)
    );

    assign m_out_byte      = res.out_byte;
    assign m_byte_valid    = res.byte_valid;
    assign m_burst_last    = res.burst_last;
    assign m_copy_pending  = res.copy_pending;
    assign m_done_res      = res.done_res;
    assign m_bad_reference = res.bad_reference;

endmodule

### rtl/blzd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blzd_port_checks
// Port-level checks on the decompressor result channel.
// ----------------------------------------------------------------------------
module blzd_port_checks (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_byte_valid,
    input logic       m_copy_pending,
    input logic       m_done_res,
    input logic       m_bad_reference
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte))
        else $error("result changed while stalled");

    // Empty status results carry a zero byte
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_out_byte == 8'd0 && !m_bad_reference)
        else $error("status result carries data");

    // A bad reference yields a zero data byte
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_reference |-> m_byte_valid && m_out_byte == 8'd0)
        else $error("bad reference byte not zero");

    // Nothing can be pending once done
    a_pend_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_copy_pending |-> !m_done_res)
        else $error("copy pending after done");

endmodule

bind backward_lz_bitstream_decompressor_unit blzd_port_checks u_blzd_port_checks (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_out_byte      (m_out_byte),
    .m_byte_valid    (m_byte_valid),
    .m_copy_pending  (m_copy_pending),
    .m_done_res      (m_done_res),
    .m_bad_reference (m_bad_reference)
);

### dv/blzd_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blzd_tb_pkg
// Request codes and sizes shared by the decompressor stimulus and its checker.
// ----------------------------------------------------------------------------
package blzd_tb_pkg;

    localparam logic REQ_BYTE  = 1'b0;   // transfer carries a compressed byte
    localparam logic REQ_DRAIN = 1'b1;   // transfer continues a pending copy or leftover bits

    localparam int BURST_MAX  = 64;
    localparam int HIST_DEPTH = 16384;

endpackage

### dv/blzd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blzd_checker
// Watches both channels of the decompressor, runs a bit-level model of the
// token decoder on every accepted input transfer and compares each result
// transfer field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module blzd_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_req_type,
    input  logic [7:0]  s_comp_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic        m_byte_valid,
    input  logic        m_burst_last,
    input  logic        m_copy_pending,
    input  logic        m_done_res,
    input  logic        m_bad_reference,
    output int          fail_count,
    output int          results_owed
);

    // Model state
    logic [7:0]         hist_mem [blzd_tb_pkg::HIST_DEPTH];
    logic [31:0]        out_size;
    logic [7:0]         pool;
    int                 pool_left;
    blzd_pkg::phase_t   dec_phase;
    logic [12:0]        accum;
    int                 accum_bits;
    int                 level;
    logic [31:0]        copy_left;
    logic [13:0]        copy_dist;
    logic [31:0]        made;

    blzd_pkg::res_t burst_q [$];
    blzd_pkg::res_t owed_q  [$];
    int   errs;

    assign fail_count = errs;

    initial begin
        errs = 0;
        results_owed = 0;
    end

    function automatic bit size_reached();
        return made >= out_size;
    endfunction

    function automatic int width_of_level(input int lvl);
        case (lvl & 3)
            0:       return 2;
            1:       return 3;
            2:       return 5;
            default: return 8;
        endcase
    endfunction

    // Queue one result of the current burst; drop past the burst limit
    task automatic emit(input logic [7:0] val, input logic vld, input logic bad);
        blzd_pkg::res_t r;
        if (burst_q.size() >= blzd_tb_pkg::BURST_MAX) return;
        r.out_byte      = val;
        r.byte_valid    = vld;
        r.burst_last    = 1'b0;
        r.copy_pending  = (dec_phase == blzd_pkg::PH_COPY) && (copy_left != 0) &&
                          !size_reached();
        r.done_res      = size_reached();
        r.bad_reference = bad;
        burst_q = {burst_q, r};
    endtask

    task automatic produce(input logic [7:0] val, input logic bad);
        hist_mem[made % blzd_tb_pkg::HIST_DEPTH] = val;
        made = made + 1;
        emit(val, 1'b1, bad);
    endtask

    task automatic add_length(input logic [31:0] v);
        logic [32:0] s;
        s = {1'b0, copy_left} + {1'b0, v};
        copy_left = s[32] ? 32'hFFFF_FFFF : s[31:0];
    endtask

    task automatic begin_field(input blzd_pkg::phase_t ph);
        dec_phase  = ph;
        accum      = '0;
        accum_bits = 0;
    endtask

    // Emit copy bytes until the burst fills, the copy ends or the size is hit
    task automatic run_copy();
        logic [7:0] val;
        logic       bad;
        while (copy_left != 0 && burst_q.size() < blzd_tb_pkg::BURST_MAX &&
               !size_reached()) begin
            val = '0;
            bad = 1'b1;
            if ({18'd0, copy_dist} <= made) begin
                val = hist_mem[(made - {18'd0, copy_dist}) % blzd_tb_pkg::HIST_DEPTH];
                bad = 1'b0;
            end
            copy_left = copy_left - 1;
            produce(val, bad);
        end
        if (copy_left == 0 || size_reached()) begin
            copy_left = '0;
            dec_phase = blzd_pkg::PH_FLAG;
        end
    endtask

    task automatic feed_bit(input logic b);
        int w;
        logic [31:0] v;
        if (dec_phase == blzd_pkg::PH_FLAG) begin
            begin_field(b ? blzd_pkg::PH_DIST : blzd_pkg::PH_LIT);
            return;
        end
        accum = {accum[11:0], b};
        accum_bits++;
        case (dec_phase)
            blzd_pkg::PH_LIT: begin
                if (accum_bits == 8) begin
                    produce(accum[7:0], 1'b0);
                    begin_field(blzd_pkg::PH_FLAG);
                end
            end
            blzd_pkg::PH_DIST: begin
                if (accum_bits == blzd_pkg::DIST_BITS) begin
                    copy_dist = {1'b0, accum} + 14'd3;
                    copy_left = 32'd3;
                    level     = 0;
                    begin_field(blzd_pkg::PH_LEVEL);
                end
            end
            blzd_pkg::PH_LEVEL: begin
                w = width_of_level(level);
                if (accum_bits == w) begin
                    v = {19'd0, accum};
                    add_length(v);
                    if (v == (32'd1 << w) - 1) begin
                        level++;
                        begin_field(level >= blzd_pkg::LEVELS ? blzd_pkg::PH_EXT :
                                                                blzd_pkg::PH_LEVEL);
                    end else begin
                        begin_field(blzd_pkg::PH_COPY);
                        run_copy();
                    end
                end
            end
            blzd_pkg::PH_EXT: begin
                if (accum_bits == 8) begin
                    v = {19'd0, accum};
                    add_length(v);
                    if (v != {24'd0, blzd_pkg::EXT_CONT}) begin
                        begin_field(blzd_pkg::PH_COPY);
                        run_copy();
                    end else begin
                        begin_field(blzd_pkg::PH_EXT);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic run_pool();
        while (pool_left > 0 && dec_phase != blzd_pkg::PH_COPY && !size_reached()) begin
            pool_left--;
            feed_bit(pool[pool_left]);
        end
    endtask

    // Predict the full burst for one accepted input transfer
    task automatic decode_transfer(input logic req, input logic [7:0] cb);
        burst_q.delete();
        if (!size_reached()) begin
            if (req == blzd_tb_pkg::REQ_BYTE) begin
                if (dec_phase != blzd_pkg::PH_COPY) begin
                    pool      = cb;
                    pool_left = 8;
                    run_pool();
                end
            end else begin
                if (dec_phase == blzd_pkg::PH_COPY) run_copy();
                run_pool();
            end
        end
        if (burst_q.size() == 0) emit(8'd0, 1'b0, 1'b0);
        burst_q[burst_q.size() - 1].burst_last = 1'b1;
        owed_q = {owed_q, burst_q};
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t ns: %s is %0d, expected %0d", $time, field, got, want);
        errs++;
    endtask

    always @(posedge aclk) begin
        blzd_pkg::res_t want;
        if (!aresetn) begin
            out_size   = '0;
            pool       = '0;
            pool_left  = 0;
            dec_phase  = blzd_pkg::PH_FLAG;
            accum      = '0;
            accum_bits = 0;
            level      = 0;
            copy_left  = '0;
            copy_dist  = '0;
            made       = '0;
            owed_q.delete();
        end else begin
            if (cfg_wr_en) out_size = cfg_wr_data;
            if (s_valid && s_ready) decode_transfer(s_req_type, s_comp_byte);
            // Compare each result transfer against the oldest prediction
            if (m_valid && m_ready) begin
                if (owed_q.size() == 0) begin
                    $display("%0t ns: result transfer with no prediction waiting", $time);
                    errs++;
                end else begin
                    want = owed_q.pop_front();
                    if (m_out_byte !== want.out_byte)
                        report_mismatch("out_byte", m_out_byte, want.out_byte);
                    if (m_byte_valid !== want.byte_valid)
                        report_mismatch("byte_valid", m_byte_valid, want.byte_valid);
                    if (m_burst_last !== want.burst_last)
                        report_mismatch("burst_last", m_burst_last, want.burst_last);
                    if (m_copy_pending !== want.copy_pending)
                        report_mismatch("copy_pending", m_copy_pending, want.copy_pending);
                    if (m_done_res !== want.done_res)
                        report_mismatch("done_res", m_done_res, want.done_res);
                    if (m_bad_reference !== want.bad_reference)
                        report_mismatch("bad_reference", m_bad_reference,
                                        want.bad_reference);
                end
            end
        end
        results_owed <= owed_q.size();
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives well-formed backward LZ token streams (literals, overlapping and
// out-of-range copies, multi-level and extended lengths) into the
// decompressor with drain transfers for long copies, under several output
// size settings and handshake idling patterns; the checker scores results.
// ----------------------------------------------------------------------------
module testbench;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_req_type;
    logic [7:0]  s_comp_byte;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic        m_byte_valid;
    logic        m_burst_last;
    logic        m_copy_pending;
    logic        m_done_res;
    logic        m_bad_reference;
    int          fail_count;
    int          results_owed;

    int tx_idle_pct;
    int rx_idle_pct;
    int sent_items;
    int seen_results;
    int seen_bytes;
    int seen_bad;

    // Stream under construction: bits MSB first, bytes produced per bit
    logic      stream_bits [$];
    int        bit_yield   [$];
    bit        bit_long    [$];
    logic      item_req    [$];
    logic [7:0] item_data  [$];
    int        enc_made;
    int        planned;

    backward_lz_bitstream_decompressor_unit DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_comp_byte     (s_comp_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_byte_valid    (m_byte_valid),
        .m_burst_last    (m_burst_last),
        .m_copy_pending  (m_copy_pending),
        .m_done_res      (m_done_res),
        .m_bad_reference (m_bad_reference)
    );

    blzd_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_comp_byte     (s_comp_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_byte_valid    (m_byte_valid),
        .m_burst_last    (m_burst_last),
        .m_copy_pending  (m_copy_pending),
        .m_done_res      (m_done_res),
        .m_bad_reference (m_bad_reference),
        .fail_count      (fail_count),
        .results_owed    (results_owed)
    );

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Throttle the result channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Tally result transfers for the summary and for sizing the next phase
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_results++;
            if (m_byte_valid) seen_bytes++;
            if (m_bad_reference) seen_bad++;
        end
    end

    // Hard stop
    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic put_bits(input int val, input int width, input int yield, input bit lng);
        for (int i = width - 1; i >= 0; i--) begin
            stream_bits = {stream_bits, val[i]};
            bit_yield   = {bit_yield, (i == 0 ? yield : 0)};
            bit_long    = {bit_long, (i == 0 ? lng : 1'b0)};
        end
    endtask

    task automatic put_literal(input logic [7:0] val);
        put_bits(0, 1, 0, 1'b0);
        put_bits(val, 8, 1, 1'b0);
        enc_made++;
        planned++;
    endtask

    // Encode a copy: distance field, then length levels and extensions
    task automatic put_copy(input int field, input int len);
        int rem;
        int w;
        int mx;
        bit lng;
        rem = len - 3;
        lng = (len > blzd_tb_pkg::BURST_MAX);
        put_bits(1, 1, 0, 1'b0);
        put_bits(field, blzd_pkg::DIST_BITS, 0, 1'b0);
        for (int lvl = 0; lvl < blzd_pkg::LEVELS; lvl++) begin
            w  = (lvl == 0) ? 2 : (lvl == 1) ? 3 : (lvl == 2) ? 5 : 8;
            mx = (1 << w) - 1;
            if (rem < mx) begin
                put_bits(rem, w, len, lng);
                rem = -1;
                break;
            end
            put_bits(mx, w, 0, 1'b0);
            rem -= mx;
        end
        if (rem >= 0) begin
            while (rem >= blzd_pkg::EXT_CONT) begin
                put_bits(blzd_pkg::EXT_CONT, 8, 0, 1'b0);
                rem -= blzd_pkg::EXT_CONT;
            end
            put_bits(rem, 8, len, lng);
        end
        enc_made += len;
        planned  += len;
    endtask

    task automatic push_item(input logic req, input logic [7:0] val);
        item_req  = {item_req, req};
        item_data = {item_data, val};
    endtask

    // Cut whole bytes off the stream; follow each with enough drains
    task automatic pack_items(input bit noisy);
        logic [7:0] val;
        int yield;
        bit lng;
        int drains;
        while (stream_bits.size() >= 8) begin
            yield = 0;
            lng   = 1'b0;
            for (int i = 7; i >= 0; i--) begin
                val[i] = stream_bits.pop_front();
                yield += bit_yield.pop_front();
                lng   |= bit_long.pop_front();
            end
            push_item(blzd_tb_pkg::REQ_BYTE, val);
            drains = (yield > 0) ? (yield - 1) / blzd_tb_pkg::BURST_MAX : 0;
            // A byte sent while the copy is still pending is dropped
            if (noisy && lng && $urandom_range(2) == 0)
                push_item(blzd_tb_pkg::REQ_BYTE, 8'($urandom));
            repeat (drains) push_item(blzd_tb_pkg::REQ_DRAIN, 8'($urandom));
            if (noisy && $urandom_range(99) < 5)
                push_item(blzd_tb_pkg::REQ_DRAIN, 8'($urandom));
        end
    endtask

    // Pad with literals to a byte boundary so the next stream stays aligned
    task automatic close_stream(input bit noisy);
        while (stream_bits.size() % 8 != 0) put_literal(8'($urandom));
        pack_items(noisy);
    endtask

    task automatic random_stream(input int n_items, input bit noisy);
        int r;
        int len;
        int reach;
        int field;
        while (item_req.size() < n_items) begin
            if (enc_made < 3 || $urandom_range(99) < 65) begin
                put_literal(8'($urandom));
            end else begin
                r = $urandom_range(99);
                if (r < 70)      len = $urandom_range(10, 3);
                else if (r < 90) len = $urandom_range(70, 11);
                else if (r < 98) len = $urandom_range(300, 71);
                else             len = $urandom_range(1200, 301);
                reach = (enc_made < 8194) ? enc_made : 8194;
                if ($urandom_range(99) < 3)
                    field = $urandom_range(8191);
                else if ($urandom_range(1) == 0)
                    field = $urandom_range((reach - 3 < 15) ? reach - 3 : 15);
                else
                    field = $urandom_range(reach - 3);
                put_copy(field, len);
            end
            pack_items(noisy);
        end
        close_stream(noisy);
    endtask

    task automatic new_stream();
        stream_bits.delete();
        bit_yield.delete();
        bit_long.delete();
        item_req.delete();
        item_data.delete();
        enc_made = seen_bytes;
        planned  = 0;
    endtask

    task automatic write_size(input logic [31:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Hold valid and payload until the transfer completes
    task automatic send_item(input logic req, input logic [7:0] val);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= req;
        s_comp_byte <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_items++;
    endtask

    task automatic send_all();
        foreach (item_req[i]) send_item(item_req[i], item_data[i]);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_req_type   = blzd_tb_pkg::REQ_BYTE;
        s_comp_byte  = '0;
        tx_idle_pct  = 6;
        rx_idle_pct  = 62;
        sent_items   = 0;
        seen_results = 0;
        seen_bytes   = 0;
        seen_bad     = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero size: every transfer is ignored
        write_size(32'd0);
        send_item(blzd_tb_pkg::REQ_BYTE, 8'hA5);
        send_item(blzd_tb_pkg::REQ_DRAIN, 8'h00);
        s_valid <= 1'b0;
        wait_drained();

        // Directed tokens: extreme literals, bad reference, overlapping long copy
        new_stream();
        put_literal(8'h00);
        put_literal(8'hFF);
        put_copy(8191, 3);
        put_literal(8'h5A);
        put_copy(0, 70);
        put_copy(1, 6);
        put_copy(2, 13);
        put_literal(8'h81);
        close_stream(1'b0);
        write_size(32'(seen_bytes + planned));
        send_all();
        wait_drained();

        // Sender mostly busy, receiver mostly stalled, exact size
        new_stream();
        random_stream(130, 1'b0);
        write_size(32'(seen_bytes + planned));
        send_all();
        wait_drained();

        // Sender mostly idle, receiver mostly ready, unlimited size
        tx_idle_pct = 62;
        rx_idle_pct = 6;
        new_stream();
        random_stream(130, 1'b0);
        write_size(32'hFFFF_FFFF);
        send_all();
        wait_drained();

        // Full rate with ignored bytes and spare drains; size cuts the stream short
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        new_stream();
        random_stream(135, 1'b1);
        write_size(32'(seen_bytes + planned - 5));
        send_all();
        wait_drained();

        // Raise the size again and let the leftover bits resume
        write_size(32'hFFFF_FFFF);
        repeat (4) send_item(blzd_tb_pkg::REQ_DRAIN, 8'($urandom));
        s_valid <= 1'b0;
        wait_drained();

        $display("covered %0d input transfers, %0d result transfers, %0d bytes out",
                 sent_items, seen_results, seen_bytes);
        $display("%0d bad references over six size settings", seen_bad);
        if (fail_count == 0 && results_owed == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### files.f
rtl/blzd_pkg.sv
rtl/blzd_front.sv
rtl/blzd_engine.sv
rtl/backward_lz_bitstream_decompressor_unit.sv
rtl/blzd_checker.sv
dv/blzd_tb_pkg.sv
dv/blzd_checker.sv
dv/testbench.sv
